// ----- rtl/differential_pid_line_steer_defines.svh -----
// Assertion macros for the differential PID line steering block.
// Included by the top level; the macros expect clk and arst_n in scope.
`ifndef DIFFERENTIAL_PID_LINE_STEER_DEFINES_SVH
`define DIFFERENTIAL_PID_LINE_STEER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dpls_pkg.sv -----
// Shared types and constants for the differential PID line steering block.
// No dependencies; every RTL module imports this package.
`default_nettype none

package dpls_pkg;

	// Fixed field widths.
	localparam int SENSOR_BITS = 8;
	localparam int ERR_BITS    = SENSOR_BITS + 1;
	localparam int DER_BITS    = SENSOR_BITS + 2;
	localparam int GAIN_BITS   = 12;
	localparam int DRIVE_BITS  = 7;
	localparam int TURN_BITS   = DRIVE_BITS + 2;
	localparam int TURN_LIM    = (1 << (DRIVE_BITS + 1)) - 1;

	// Defaults for the top-level parameters.
	localparam int SUM_BITS_DEF       = 24;
	localparam int GAIN_FRAC_BITS_DEF = 8;

	// Configuration port.
	localparam int CFG_DATA_BITS  = GAIN_BITS;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INT_GAIN    = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE_LIMIT = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_START_SPEED = 3'd4;

	localparam logic [DRIVE_BITS-1:0] DRIVE_LIMIT_RST = 7'd127;
	localparam logic [DRIVE_BITS-1:0] START_SPEED_RST = 7'd70;

	typedef struct packed {
		logic [SENSOR_BITS-1:0] left_sensor;
		logic [SENSOR_BITS-1:0] right_sensor;
	} dpls_sample_t;

	typedef struct packed {
		logic [DRIVE_BITS-1:0] left_drive_out;
		logic [DRIVE_BITS-1:0] right_drive_out;
	} dpls_drive_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0] prop_gain;
		logic [GAIN_BITS-1:0] int_gain;
		logic [GAIN_BITS-1:0] deriv_gain;
	} dpls_gains_t;

	// Load enables for the stages of the gain unit.
	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} dpls_mac_en_t;

endpackage

`default_nettype wire

// ----- rtl/dpls_integ.sv -----
// Error, saturating integral and derivative stage of the line steering pipeline.
// Depends on dpls_pkg.
`default_nettype none

module dpls_integ #(
	parameter int SUM_BITS = dpls_pkg::SUM_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  en,
	input  dpls_pkg::dpls_sample_t               sample_s1,
	output logic signed [SUM_BITS-1:0]           error_sum,
	output logic signed [dpls_pkg::ERR_BITS-1:0] last_error,
	output logic signed [dpls_pkg::DER_BITS-1:0] deriv
);
	import dpls_pkg::*;

	localparam logic signed [SUM_BITS:0] SUM_MAX = {2'b00, {(SUM_BITS-1){1'b1}}};
	localparam logic signed [SUM_BITS:0] SUM_MIN = {2'b11, {(SUM_BITS-1){1'b0}}};

	logic signed [ERR_BITS-1:0] error_d;
	logic signed [SUM_BITS:0]   sum_wide;
	logic signed [SUM_BITS-1:0] sum_sat;
	logic signed [DER_BITS-1:0] deriv_d;
	logic signed [SUM_BITS-1:0] error_sum_q;
	logic signed [ERR_BITS-1:0] last_error_q;
	logic signed [DER_BITS-1:0] deriv_s2;

	assign error_d  = $signed({1'b0, sample_s1.left_sensor})
		- $signed({1'b0, sample_s1.right_sensor});
	assign sum_wide = (SUM_BITS+1)'(error_sum_q) + (SUM_BITS+1)'(error_d);
	assign deriv_d  = DER_BITS'(error_d) - DER_BITS'(last_error_q);

	always_comb begin
		if (sum_wide > SUM_MAX) begin
			sum_sat = SUM_MAX[SUM_BITS-1:0];
		end else if (sum_wide < SUM_MIN) begin
			sum_sat = SUM_MIN[SUM_BITS-1:0];
		end else begin
			sum_sat = sum_wide[SUM_BITS-1:0];
		end
	end

	// The integrator state doubles as the stage register: the item in this
	// stage always owns the latest integral and error.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (en) begin
			error_sum_q  <= sum_sat;
			last_error_q <= error_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deriv_s2 <= deriv_d;
		end
	end

	assign error_sum  = error_sum_q;
	assign last_error = last_error_q;
	assign deriv      = deriv_s2;

endmodule

`default_nettype wire

// ----- rtl/dpls_mac.sv -----
// Gain multiply, sum and turn stages of the line steering pipeline.
// Depends on dpls_pkg.
`default_nettype none

module dpls_mac #(
	parameter int SUM_BITS       = dpls_pkg::SUM_BITS_DEF,
	parameter int GAIN_FRAC_BITS = dpls_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire                                   clk,
	input  dpls_pkg::dpls_mac_en_t                en,
	input  dpls_pkg::dpls_gains_t                 gains,
	input  wire signed [dpls_pkg::ERR_BITS-1:0]   error,
	input  wire signed [SUM_BITS-1:0]             error_sum,
	input  wire signed [dpls_pkg::DER_BITS-1:0]   deriv,
	output logic signed [dpls_pkg::TURN_BITS-1:0] turn
);
	import dpls_pkg::*;

	localparam int P_W   = GAIN_BITS + 1 + ERR_BITS;
	localparam int I_W   = GAIN_BITS + 1 + SUM_BITS;
	localparam int D_W   = GAIN_BITS + 1 + DER_BITS;
	localparam int ACC_W = I_W + 2;

	localparam logic signed [ACC_W-1:0] BIAS = {{(ACC_W-GAIN_FRAC_BITS){1'b0}},
		{GAIN_FRAC_BITS{1'b1}}};
	localparam logic signed [ACC_W-1:0] NO_BIAS = '0;
	localparam logic signed [ACC_W-1:0] TMAX = ACC_W'(TURN_LIM);
	localparam logic signed [ACC_W-1:0] TMIN = -TMAX;

	logic signed [P_W-1:0]       prop_d,  prop_s3;
	logic signed [I_W-1:0]       integ_d, integ_s3;
	logic signed [D_W-1:0]       deriv_d, deriv_s3;
	logic signed [ACC_W-1:0]     acc_d,   acc_s4;
	logic signed [ACC_W-1:0]     quot;
	logic signed [TURN_BITS-1:0] turn_d,  turn_s5;

	assign prop_d  = $signed({1'b0, gains.prop_gain}) * error;
	assign integ_d = $signed({1'b0, gains.int_gain}) * error_sum;
	assign deriv_d = $signed({1'b0, gains.deriv_gain}) * deriv;

	assign acc_d = ACC_W'(prop_s3) + ACC_W'(integ_s3) + ACC_W'(deriv_s3);

	// Arithmetic shift rounds down; a negative sum is biased first so the
	// quotient rounds toward zero. Both arms of the bias select are signed so
	// that the shift stays arithmetic.
	assign quot = (acc_s4 + (acc_s4[ACC_W-1] ? BIAS : NO_BIAS)) >>> GAIN_FRAC_BITS;

	// A turn past the drive span saturates every drive the same way, so it
	// is narrowed here to keep the drive loop short.
	always_comb begin
		if (quot > TMAX) begin
			turn_d = TMAX[TURN_BITS-1:0];
		end else if (quot < TMIN) begin
			turn_d = TMIN[TURN_BITS-1:0];
		end else begin
			turn_d = quot[TURN_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prop_s3  <= prop_d;
			integ_s3 <= integ_d;
			deriv_s3 <= deriv_d;
		end
		if (en.s4) begin
			acc_s4 <= acc_d;
		end
		if (en.s5) begin
			turn_s5 <= turn_d;
		end
	end

	assign turn = turn_s5;

endmodule

`default_nettype wire

// ----- rtl/dpls_drive.sv -----
// Motor drive accumulators with clamping; they also form the result register.
// Depends on dpls_pkg.
`default_nettype none

module dpls_drive (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  en,
	input  wire                                  load_speed,
	input  wire [dpls_pkg::DRIVE_BITS-1:0]       start_speed,
	input  wire [dpls_pkg::DRIVE_BITS-1:0]       drive_limit,
	input  wire signed [dpls_pkg::TURN_BITS-1:0] turn,
	output dpls_pkg::dpls_drive_t                drive
);
	import dpls_pkg::*;

	localparam int DRV_W = TURN_BITS + 1;

	logic [DRIVE_BITS-1:0]   left_q, right_q;
	logic signed [DRV_W-1:0] left_raw, right_raw, limit_w;
	logic [DRIVE_BITS-1:0]   left_d, right_d;

	assign limit_w   = $signed({{(DRV_W-DRIVE_BITS){1'b0}}, drive_limit});
	assign left_raw  = $signed({{(DRV_W-DRIVE_BITS){1'b0}}, left_q}) - DRV_W'(turn);
	assign right_raw = $signed({{(DRV_W-DRIVE_BITS){1'b0}}, right_q}) + DRV_W'(turn);

	always_comb begin
		if (left_raw < 0) begin
			left_d = '0;
		end else if (left_raw > limit_w) begin
			left_d = drive_limit;
		end else begin
			left_d = left_raw[DRIVE_BITS-1:0];
		end
		if (right_raw < 0) begin
			right_d = '0;
		end else if (right_raw > limit_w) begin
			right_d = drive_limit;
		end else begin
			right_d = right_raw[DRIVE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= START_SPEED_RST;
			right_q <= START_SPEED_RST;
		end else if (load_speed) begin
			left_q  <= start_speed;
			right_q <= start_speed;
		end else if (en) begin
			left_q  <= left_d;
			right_q <= right_d;
		end
	end

	assign drive.left_drive_out  = left_q;
	assign drive.right_drive_out = right_q;

endmodule

`default_nettype wire

// ----- rtl/differential_pid_line_steer.sv -----
// Differential PID line steering. Each transfer on the sample channel carries
// one left/right line-sensor pair; the block forms the error left minus right,
// a saturating integral and a derivative, weights them with three unsigned
// Q(12-F).F gains, truncates the sum toward zero to an integer turn, subtracts the
// turn from the left drive and adds it to the right drive, clamps both drives
// to 0..drive_limit and returns them as one transfer on the drive channel.
// The block takes one sample per clock cycle when the drive side keeps up. The
// rate is set by two feedback loops that each close through one register: the
// integral update (one add and saturate) and the drive update (one add and
// clamp). Between them sit a multiply stage, a sum stage and a rounding stage,
// each registered. Stages hold independently, so empty stages fill up while a
// result is stalled; sample_stall rises only when every stage and the result
// register are full and the result is stalled.
// Configuration is written through cfg_we/cfg_index/cfg_data and should only be
// written while no results are outstanding. Writing start_speed loads both
// drives with the new value at once.
`default_nettype none
`include "differential_pid_line_steer_defines.svh"

module differential_pid_line_steer #(
	parameter int SUM_BITS       = dpls_pkg::SUM_BITS_DEF,
	parameter int GAIN_FRAC_BITS = dpls_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    sample_valid,
	output logic                                   sample_stall,
	input  dpls_pkg::dpls_sample_t                 sample,
	output logic                                   drive_valid,
	input  wire                                    drive_stall,
	output dpls_pkg::dpls_drive_t                  drive,
	input  wire                                    cfg_we,
	input  wire [dpls_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire [dpls_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
	import dpls_pkg::*;

	// Gain reset values follow the fraction width: 0.1, 0.2 and 1.0.
	localparam int ONE_Q = 1 << GAIN_FRAC_BITS;
	localparam logic [GAIN_BITS-1:0] PROP_GAIN_RST  = GAIN_BITS'((ONE_Q + 5) / 10);
	localparam logic [GAIN_BITS-1:0] INT_GAIN_RST   = GAIN_BITS'((2 * ONE_Q + 5) / 10);
	localparam logic [GAIN_BITS-1:0] DERIV_GAIN_RST = GAIN_BITS'(ONE_Q);

	// Configuration registers.
	dpls_gains_t           gains_q;
	logic [DRIVE_BITS-1:0] drive_limit_q;
	logic [DRIVE_BITS-1:0] start_speed_q;
	logic                  load_speed;

	// Pipeline occupancy. Each stage loads when its upstream neighbor holds
	// an item and it is either empty or emptying in the same cycle.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_v_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_out;
	logic en_s1, en_s2, en_out;
	dpls_mac_en_t mac_en;

	dpls_sample_t                sample_s1;
	logic signed [SUM_BITS-1:0]  error_sum;
	logic signed [ERR_BITS-1:0]  last_error;
	logic signed [DER_BITS-1:0]  deriv;
	logic signed [TURN_BITS-1:0] turn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop_gain  <= PROP_GAIN_RST;
			gains_q.int_gain   <= INT_GAIN_RST;
			gains_q.deriv_gain <= DERIV_GAIN_RST;
			drive_limit_q      <= DRIVE_LIMIT_RST;
			start_speed_q      <= START_SPEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:   gains_q.prop_gain  <= cfg_data;
				REG_INT_GAIN:    gains_q.int_gain   <= cfg_data;
				REG_DERIV_GAIN:  gains_q.deriv_gain <= cfg_data;
				REG_DRIVE_LIMIT: drive_limit_q      <= cfg_data[DRIVE_BITS-1:0];
				REG_START_SPEED: start_speed_q      <= cfg_data[DRIVE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign load_speed = cfg_we && (cfg_index == REG_START_SPEED);

	assign rdy_out = !out_v_q || !drive_stall;
	assign rdy_s5  = !v_s5 || rdy_out;
	assign rdy_s4  = !v_s4 || rdy_s5;
	assign rdy_s3  = !v_s3 || rdy_s4;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;

	assign en_s1     = sample_valid && rdy_s1;
	assign en_s2     = v_s1 && rdy_s2;
	assign mac_en.s3 = v_s2 && rdy_s3;
	assign mac_en.s4 = v_s3 && rdy_s4;
	assign mac_en.s5 = v_s4 && rdy_s5;
	assign en_out    = v_s5 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= sample_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
			if (rdy_out) begin
				out_v_q <= v_s5;
			end
		end
	end

	// Sample input register.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			sample_s1 <= sample;
		end
	end

	dpls_integ #(
		.SUM_BITS(SUM_BITS)
	) u_integ (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en_s2),
		.sample_s1  (sample_s1),
		.error_sum  (error_sum),
		.last_error (last_error),
		.deriv      (deriv)
	);

	dpls_mac #(
		.SUM_BITS       (SUM_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_mac (
		.clk       (clk),
		.en        (mac_en),
		.gains     (gains_q),
		.error     (last_error),
		.error_sum (error_sum),
		.deriv     (deriv),
		.turn      (turn)
	);

	// The drive accumulators are the result register.
	dpls_drive u_drive (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en_out),
		.load_speed  (load_speed),
		.start_speed (cfg_data[DRIVE_BITS-1:0]),
		.drive_limit (drive_limit_q),
		.turn        (turn),
		.drive       (drive)
	);

	assign sample_stall = !rdy_s1;
	assign drive_valid  = out_v_q;

	// A stall toward the sample side means the whole pipeline is full and blocked.
	`DPLS_ASSERT_NOW(a_stall_only_when_full, sample_stall,
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_v_q && drive_stall,
		"sample stall raised while the pipeline still has room")

	// A turn waiting behind a stalled result must not be overwritten.
	`DPLS_ASSERT_NEXT(a_turn_held, v_s5 && out_v_q && drive_stall,
		$stable(turn),
		"pending turn changed while the result was stalled")

	// Writing start_speed loads both drives on the next edge.
	`DPLS_ASSERT_NEXT(a_speed_load, load_speed,
		(drive.left_drive_out == $past(cfg_data[DRIVE_BITS-1:0]))
		&& (drive.right_drive_out == $past(cfg_data[DRIVE_BITS-1:0])),
		"start speed write did not load the drives")

endmodule

`default_nettype wire

// ----- tb/sv/tb_differential_pid_line_steer.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the differential PID line steering block.
// Depends on dpls_pkg and the differential_pid_line_steer RTL; reads no files.

module tb_differential_pid_line_steer;
	import dpls_pkg::*;

	// The predictor works at the block's default parameter values.
	localparam int     SUM_W      = SUM_BITS_DEF;
	localparam int     FRAC_W     = GAIN_FRAC_BITS_DEF;
	localparam longint SUM_HI     = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
	localparam longint SUM_LO     = -SUM_HI - 64'sd1;
	localparam longint ONE_Q      = 64'sd1 <<< FRAC_W;
	localparam int     SENSOR_MAX = (1 << SENSOR_BITS) - 1;
	localparam int     GAIN_MAX   = (1 << GAIN_BITS) - 1;
	localparam int     DRIVE_MAX  = (1 << DRIVE_BITS) - 1;

	// Gain values the block comes out of reset with: 0.1, 0.2 and 1.0 in Q4.8.
	localparam logic [GAIN_BITS-1:0] PROP_GAIN_RST  = 12'd26;
	localparam logic [GAIN_BITS-1:0] INT_GAIN_RST   = 12'd51;
	localparam logic [GAIN_BITS-1:0] DERIV_GAIN_RST = 12'd256;

	// Register indexes that decode to nothing; writes there must be dropped.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

	localparam int     RESET_CYCLES  = 9;
	localparam int     SETTLE_CYCLES = 12;   // idle stretch after the last result before a write
	localparam int     HOLD_CYCLES   = 400;  // long receiver hold-off for back-pressure
	localparam int     RANDOM_PHASES = 6;
	localparam int     PHASE_ITEMS   = 280;
	localparam int     BURST_ITEMS   = 60;   // gap-free transfers at full rate
	localparam int     TAIL_ITEMS    = 50;
	localparam int     REPORT_LIMIT  = 10;
	localparam longint CYCLE_LIMIT   = 1_500_000;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	// One line of the directed plan. For a write, a is the register index and b
	// the data. For a sample, a and b are the left and right readings, and when
	// pinned is set the drives are typed in rather than predicted.
	typedef struct {
		row_kind_t kind;
		int        a;
		int        b;
		bit        pinned;
		int        want_l;
		int        want_r;
	} plan_row_t;

	// Clock, reset and the block's ports. Every input is known from time zero.
	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      sample_valid = 1'b0;
	logic                      sample_stall;
	dpls_sample_t              sample       = '0;
	logic                      drive_valid;
	logic                      drive_stall  = 1'b0;
	dpls_drive_t               drive;
	logic                      cfg_we       = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

	// Predictor copy of the registers and of the loop state.
	logic        [GAIN_BITS-1:0]  prop_g, int_g, deriv_g;
	logic        [DRIVE_BITS-1:0] limit_r, start_r;
	logic signed [SUM_W-1:0]      integ;
	logic signed [ERR_BITS-1:0]   prev_err;
	logic        [DRIVE_BITS-1:0] left_d, right_d;

	// Drive pairs predicted for accepted samples, oldest first.
	dpls_drive_t drive_due_q[$];
	plan_row_t   plan[$];

	int     fail_count    = 0;
	longint cycle_count   = 0;
	bit     quiet         = 1'b0;   // no sender gaps and no new stalls picked while set
	int     burst_left    = 0;      // sender transfers left in a gap-free burst
	int     hold_requests = 0;      // bumped by the stimulus process
	int     holds_done    = 0;      // owned by the receiver process
	int     stall_run     = 0;
	bit     stall_on      = 1'b0;
	int     rx_pick;

	differential_pid_line_steer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.drive        (drive),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// Watchdog. A hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic load_reset_state();
		prop_g   = PROP_GAIN_RST;
		int_g    = INT_GAIN_RST;
		deriv_g  = DERIV_GAIN_RST;
		limit_r  = DRIVE_LIMIT_RST;
		start_r  = START_SPEED_RST;
		integ    = '0;
		prev_err = '0;
		left_d   = START_SPEED_RST;
		right_d  = START_SPEED_RST;
	endtask

	function automatic logic [DRIVE_BITS-1:0] clamp_drive(input longint v);
		if (v > longint'(limit_r))
			v = longint'(limit_r);
		if (v < 0)
			v = 0;
		return v[DRIVE_BITS-1:0];
	endfunction

	// Advances the predictor by one sample and returns the drives it leads to.
	// The gain-weighted sum is exact in Q.8; the division by 2^8 on a signed
	// longint truncates toward zero, which is the rounding the block uses.
	function automatic dpls_drive_t steer_step(input dpls_sample_t s);
		longint      err, total, acc, turn;
		dpls_drive_t d;
		err   = longint'(s.left_sensor) - longint'(s.right_sensor);
		total = longint'(integ) + err;
		if (total > SUM_HI)
			total = SUM_HI;
		if (total < SUM_LO)
			total = SUM_LO;
		integ = total[SUM_W-1:0];
		acc = longint'(prop_g) * err
			+ longint'(int_g) * total
			+ longint'(deriv_g) * (err - longint'(prev_err));
		turn     = acc / ONE_Q;
		left_d   = clamp_drive(longint'(left_d) - turn);
		right_d  = clamp_drive(longint'(right_d) + turn);
		prev_err = err[ERR_BITS-1:0];
		d.left_drive_out  = left_d;
		d.right_drive_out = right_d;
		return d;
	endfunction

	// Sender idle length after a transfer: mostly none or short, now and then
	// long, and every so often a burst of back-to-back transfers.
	function automatic int sender_gap();
		int r;
		if (quiet)
			return 0;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			burst_left = $urandom_range(30, 120);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Random sensor pair. Half the pairs sit close together, as they do when the
	// vehicle tracks the line; the rest are fully random or at the rails.
	function automatic dpls_sample_t pick_sample();
		dpls_sample_t s;
		int           mode, base, near;
		mode           = $urandom_range(0, 9);
		s.left_sensor  = SENSOR_BITS'($urandom_range(0, SENSOR_MAX));
		s.right_sensor = SENSOR_BITS'($urandom_range(0, SENSOR_MAX));
		if (mode == 0) begin
			if ($urandom_range(0, 1))
				s.left_sensor = SENSOR_BITS'($urandom_range(0, 1) ? SENSOR_MAX : 0);
			if ($urandom_range(0, 1))
				s.right_sensor = SENSOR_BITS'($urandom_range(0, 1) ? SENSOR_MAX : 0);
		end else if (mode <= 5) begin
			base = $urandom_range(0, SENSOR_MAX);
			near = base + int'($urandom_range(0, 16)) - 8;
			if (near < 0)
				near = 0;
			if (near > SENSOR_MAX)
				near = SENSOR_MAX;
			s.left_sensor  = SENSOR_BITS'(base);
			s.right_sensor = SENSOR_BITS'(near);
		end
		return s;
	endfunction

	function automatic void add_row(input row_kind_t kind, input int a, input int b,
			input bit pinned = 1'b0, input int want_l = 0, input int want_r = 0);
		plan_row_t row;
		row.kind   = kind;
		row.a      = a;
		row.b      = b;
		row.pinned = pinned;
		row.want_l = want_l;
		row.want_r = want_r;
		plan.push_back(row);
	endfunction

	// Offers one sample and holds it until the block takes it. The predictor
	// advances on the accepting edge. A pinned expectation replaces the
	// predicted one, but the predictor still steps so its state stays in line.
	task automatic push_sample(input dpls_sample_t s, input bit pinned, input dpls_drive_t fixed);
		dpls_drive_t d;
		int          gap;
		sample       <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		d = steer_step(s);
		drive_due_q.push_back(pinned ? fixed : d);
		gap = sender_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every predicted transfer has come back, then lets the
	// pipeline run dry, so that a register write lands on an idle block.
	task automatic settle();
		sample_valid <= 1'b0;
		while (drive_due_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write. The enable is dropped after the next edge, in its own step, so
	// that back-to-back writes never schedule two updates of cfg_we at once.
	task automatic set_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_PROP_GAIN:   prop_g  = data[GAIN_BITS-1:0];
			REG_INT_GAIN:    int_g   = data[GAIN_BITS-1:0];
			REG_DERIV_GAIN:  deriv_g = data[GAIN_BITS-1:0];
			REG_DRIVE_LIMIT: limit_r = data[DRIVE_BITS-1:0];
			REG_START_SPEED: begin
				// A new start speed is loaded into both drives at once.
				start_r = data[DRIVE_BITS-1:0];
				left_d  = start_r;
				right_d = start_r;
			end
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_drive(input dpls_drive_t got);
		dpls_drive_t want;
		if (drive_due_q.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("[%0t] drive transfer with none pending: left %0d right %0d",
					$realtime, got.left_drive_out, got.right_drive_out);
			return;
		end
		want = drive_due_q.pop_front();
		if (got.left_drive_out !== want.left_drive_out
				|| got.right_drive_out !== want.right_drive_out) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("[%0t] drive mismatch: left exp %0d got %0d, right exp %0d got %0d",
					$realtime, want.left_drive_out, got.left_drive_out,
					want.right_drive_out, got.right_drive_out);
		end
	endtask

	// Receiver. Checks each drive transfer on the edge that accepts it and
	// picks the stall for the next cycle. A hold request from the stimulus side
	// starts a long stall stretch counted down here, which fills the pipeline
	// and must push back on the sample channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if (drive_valid && !drive_stall)
				check_drive(drive);
			if (holds_done != hold_requests) begin
				holds_done = holds_done + 1;
				stall_on   = 1'b1;
				stall_run  = HOLD_CYCLES;
			end else if (stall_run > 0) begin
				stall_run--;
			end else begin
				rx_pick = $urandom_range(0, 99);
				if (quiet) begin
					stall_on  = 1'b0;
					stall_run = 0;
				end else if (rx_pick < 10) begin
					stall_on  = 1'b0;
					stall_run = $urandom_range(40, 150);
				end else if (rx_pick < 55) begin
					stall_on  = 1'b0;
					stall_run = $urandom_range(0, 8);
				end else if (rx_pick < 90) begin
					stall_on  = 1'b1;
					stall_run = $urandom_range(0, 2);
				end else if (rx_pick < 98) begin
					stall_on  = 1'b1;
					stall_run = $urandom_range(3, 12);
				end else begin
					stall_on  = 1'b1;
					stall_run = $urandom_range(20, 60);
				end
			end
			drive_stall <= stall_on;
		end
	end

	// Stimulus.
	initial begin
		dpls_sample_t              s;
		dpls_drive_t               fixed;
		logic [CFG_INDEX_BITS-1:0] idx;
		logic [CFG_DATA_BITS-1:0]  data;
		int                        ph;

		load_reset_state();

		// Directed plan. The first four transfers run on reset settings and are
		// easy to work by hand: a centered pair leaves the drives at start
		// speed, a full-scale error pins them to opposite rails, and the
		// reverse error swings them back.
		add_row(ROW_SAMPLE, 0, 0, 1'b1, 70, 70);
		add_row(ROW_SAMPLE, SENSOR_MAX, 0, 1'b1, 0, 127);
		add_row(ROW_SAMPLE, 0, SENSOR_MAX, 1'b1, 127, 0);
		add_row(ROW_SAMPLE, 0, SENSOR_MAX, 1'b1, 127, 0);
		add_row(ROW_SAMPLE, 128, 128);
		add_row(ROW_SAMPLE, 1, 0);
		add_row(ROW_SAMPLE, 0, 1);
		add_row(ROW_SAMPLE, SENSOR_MAX, SENSOR_MAX);
		// Data bits above a register's width are dropped: start speed becomes
		// zero and the drive limit stays at its maximum.
		add_row(ROW_WRITE, int'(REG_START_SPEED), 'hF80);
		add_row(ROW_WRITE, int'(REG_DRIVE_LIMIT), 'hFFF);
		add_row(ROW_SAMPLE, 0, 0);
		add_row(ROW_SAMPLE, 200, 10);
		// Writes to undecoded indexes must change nothing.
		add_row(ROW_WRITE, int'(REG_SPARE_LO), 'hABC);
		add_row(ROW_WRITE, int'(REG_SPARE_HI), 'h555);
		add_row(ROW_SAMPLE, 10, 240);
		// With all gains at zero the turn is zero, so a start speed above the
		// limit is simply clamped down to the limit on the next transfer.
		add_row(ROW_WRITE, int'(REG_PROP_GAIN), 0);
		add_row(ROW_WRITE, int'(REG_INT_GAIN), 0);
		add_row(ROW_WRITE, int'(REG_DERIV_GAIN), 0);
		add_row(ROW_WRITE, int'(REG_START_SPEED), DRIVE_MAX);
		add_row(ROW_WRITE, int'(REG_DRIVE_LIMIT), 50);
		add_row(ROW_SAMPLE, 10, 10, 1'b1, 50, 50);
		add_row(ROW_SAMPLE, SENSOR_MAX, 0);
		// Largest gains give the widest products and turns.
		add_row(ROW_WRITE, int'(REG_PROP_GAIN), GAIN_MAX);
		add_row(ROW_WRITE, int'(REG_INT_GAIN), GAIN_MAX);
		add_row(ROW_WRITE, int'(REG_DERIV_GAIN), GAIN_MAX);
		add_row(ROW_WRITE, int'(REG_DRIVE_LIMIT), DRIVE_MAX);
		add_row(ROW_SAMPLE, SENSOR_MAX, 0);
		add_row(ROW_SAMPLE, 0, SENSOR_MAX);
		add_row(ROW_SAMPLE, 0, SENSOR_MAX);
		add_row(ROW_SAMPLE, 77, 78);
		// A zero limit forces both drives to zero whatever the turn.
		add_row(ROW_WRITE, int'(REG_DRIVE_LIMIT), 0);
		add_row(ROW_SAMPLE, 100, 3, 1'b1, 0, 0);
		add_row(ROW_SAMPLE, 3, 100, 1'b1, 0, 0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				idx  = CFG_INDEX_BITS'(plan[i].a);
				data = CFG_DATA_BITS'(plan[i].b);
				settle();
				set_reg(idx, data);
			end else begin
				s.left_sensor          = SENSOR_BITS'(plan[i].a);
				s.right_sensor         = SENSOR_BITS'(plan[i].b);
				fixed.left_drive_out   = DRIVE_BITS'(plan[i].want_l);
				fixed.right_drive_out  = DRIVE_BITS'(plan[i].want_r);
				push_sample(s, plan[i].pinned, fixed);
			end
		end

		// Random phases, each under its own register setting. Two of them
		// begin with a long receiver hold-off while samples keep coming.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					set_reg(REG_PROP_GAIN, PROP_GAIN_RST);
					set_reg(REG_INT_GAIN, INT_GAIN_RST);
					set_reg(REG_DERIV_GAIN, DERIV_GAIN_RST);
					set_reg(REG_DRIVE_LIMIT, CFG_DATA_BITS'(DRIVE_LIMIT_RST));
					set_reg(REG_START_SPEED, CFG_DATA_BITS'(START_SPEED_RST));
				end
				1: begin
					set_reg(REG_PROP_GAIN, CFG_DATA_BITS'(GAIN_MAX));
					set_reg(REG_INT_GAIN, CFG_DATA_BITS'(GAIN_MAX));
					set_reg(REG_DERIV_GAIN, CFG_DATA_BITS'(GAIN_MAX));
					set_reg(REG_START_SPEED, CFG_DATA_BITS'(DRIVE_MAX));
				end
				2: begin
					set_reg(REG_PROP_GAIN, '0);
					set_reg(REG_INT_GAIN, '0);
					set_reg(REG_DERIV_GAIN, CFG_DATA_BITS'($urandom_range(0, 40)));
					set_reg(REG_DRIVE_LIMIT,
						CFG_DATA_BITS'($urandom_range(1, DRIVE_MAX - 1)));
					set_reg(REG_START_SPEED, CFG_DATA_BITS'($urandom_range(0, DRIVE_MAX)));
				end
				3: begin
					set_reg(REG_PROP_GAIN, CFG_DATA_BITS'($urandom));
					set_reg(REG_INT_GAIN, CFG_DATA_BITS'($urandom));
					set_reg(REG_DERIV_GAIN, CFG_DATA_BITS'($urandom));
					set_reg(REG_DRIVE_LIMIT, CFG_DATA_BITS'($urandom));
					set_reg(REG_START_SPEED, CFG_DATA_BITS'($urandom));
				end
				4: begin
					// Gains of the size a real tuning would use.
					set_reg(REG_PROP_GAIN, CFG_DATA_BITS'($urandom_range(0, 64)));
					set_reg(REG_INT_GAIN, CFG_DATA_BITS'($urandom_range(0, 8)));
					set_reg(REG_DERIV_GAIN, CFG_DATA_BITS'($urandom_range(0, 300)));
					set_reg(REG_DRIVE_LIMIT, CFG_DATA_BITS'(DRIVE_MAX));
					set_reg(REG_START_SPEED, '0);
					set_reg(CFG_INDEX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
						CFG_DATA_BITS'($urandom));
				end
				default: begin
					set_reg(REG_PROP_GAIN, CFG_DATA_BITS'($urandom));
					set_reg(REG_INT_GAIN, CFG_DATA_BITS'($urandom_range(0, 16)));
					set_reg(REG_DERIV_GAIN, CFG_DATA_BITS'($urandom));
					set_reg(REG_DRIVE_LIMIT, CFG_DATA_BITS'($urandom_range(0, DRIVE_MAX)));
					set_reg(REG_START_SPEED, CFG_DATA_BITS'($urandom_range(0, DRIVE_MAX)));
				end
			endcase
			if (ph == 2 || ph == RANDOM_PHASES - 1)
				hold_requests++;
			repeat (PHASE_ITEMS) push_sample(pick_sample(), 1'b0, '0);
		end

		// Full-rate stretch under the strongest integral gain: both sides run
		// without idling so transfers follow back to back, then a short mixed
		// tail brings the gaps and stalls back.
		settle();
		set_reg(REG_PROP_GAIN, CFG_DATA_BITS'($urandom));
		set_reg(REG_INT_GAIN, CFG_DATA_BITS'(GAIN_MAX));
		set_reg(REG_DERIV_GAIN, CFG_DATA_BITS'($urandom));
		set_reg(REG_DRIVE_LIMIT, CFG_DATA_BITS'(DRIVE_MAX));
		quiet = 1'b1;
		repeat (BURST_ITEMS) push_sample(pick_sample(), 1'b0, '0);
		quiet = 1'b0;
		repeat (TAIL_ITEMS) push_sample(pick_sample(), 1'b0, '0);

		settle();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
